// ===== rtl/core/zts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package zts_pkg;

  localparam int ZONE_ENTRIES = 64;
  localparam int TAG_BITS     = 16;
  localparam int TIME_BITS    = 40;

  localparam int IDX_BITS = (ZONE_ENTRIES > 1) ? $clog2(ZONE_ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ZONE_ENTRIES + 1);

  // field widths fixed by the stream format
  localparam int MODE_W   = 2;
  localparam int ZTAG_W   = 16;
  localparam int STAMP_W  = 64;
  localparam int EIDX_W   = 6;
  localparam int STAT_W   = 3;
  localparam int OTIME_W  = 40;
  localparam int FRAMES_W = 32;
  localparam int USED_W   = 7;
  localparam int GAIN_W   = 16;
  localparam int THR_W    = 20;
  localparam int CFG_W    = 20;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_SPAN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  // register indexes
  localparam logic CFG_GAIN   = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND   = 3'd0,  // added to existing entry, or read valid
    ST_NEW     = 3'd1,
    ST_DROPPED = 3'd2,
    ST_COMMIT  = 3'd3,
    ST_INVALID = 3'd4
  } status_e;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] acc;
    logic [TIME_BITS-1:0] avg;
    logic [TIME_BITS-1:0] max;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic                 frame;
    logic [IDX_BITS-1:0]  idx;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] cur;
    logic [TIME_BITS-1:0] avg;
    logic [TIME_BITS-1:0] max;
  } smooth_in_t;

  typedef struct packed {
    logic                 frame;
    logic [IDX_BITS-1:0]  idx;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] avg;
    logic [TIME_BITS-1:0] max;
  } smooth_out_t;

  typedef struct packed {
    status_e              status;
    logic [ZTAG_W-1:0]    tag;
    logic [OTIME_W-1:0]   avg;
    logic [OTIME_W-1:0]   max;
    logic [FRAMES_W-1:0]  frames;
    logic [USED_W-1:0]    used;
  } result_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/zts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/zts_smooth.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zts_smooth (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_vld_i,
  input  wire zts_pkg::smooth_in_t          in_i,
  input  wire logic [zts_pkg::GAIN_W-1:0]   gain_i,
  input  wire logic [zts_pkg::THR_W-1:0]    thresh_i,
  output logic                              out_vld_o,
  output zts_pkg::smooth_out_t              out_o
);

  import zts_pkg::*;

  localparam int PROD_W = TIME_BITS + GAIN_W + 1;

  // stage 1: distance, direction, seed decision, new maximum
  logic                 vld1_q, vld2_q, vld3_q;
  logic                 seed1_q, up1_q;
  logic [TIME_BITS-1:0] mag1_q;
  smooth_out_t          meta1_q, meta2_q, out_q;
  logic [TIME_BITS-1:0] cur1_q;
  logic                 seed2_q, up2_q;
  logic [TIME_BITS-1:0] cur2_q;
  logic [TIME_BITS-1:0] step2_q;
  logic [PROD_W-1:0]    prod;
  logic [TIME_BITS-1:0] avg_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= in_vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    seed1_q       <= in_i.avg <= TIME_BITS'(thresh_i);
    up1_q         <= in_i.cur >= in_i.avg;
    mag1_q        <= (in_i.cur >= in_i.avg) ? in_i.cur - in_i.avg : in_i.avg - in_i.cur;
    cur1_q        <= in_i.cur;
    meta1_q.frame <= in_i.frame;
    meta1_q.idx   <= in_i.idx;
    meta1_q.tag   <= in_i.tag;
    meta1_q.avg   <= in_i.avg;
    meta1_q.max   <= (in_i.cur > in_i.max) ? in_i.cur : in_i.max;
  end

  // stage 2: step = round(mag * gain / 2^16)
  assign prod = PROD_W'(mag1_q) * PROD_W'(gain_i) + PROD_W'(32768);

  always_ff @(posedge clk_i) begin
    step2_q <= prod[TIME_BITS+15:16];
    seed2_q <= seed1_q;
    up2_q   <= up1_q;
    cur2_q  <= cur1_q;
    meta2_q <= meta1_q;
  end

  // stage 3: move toward the new sum, the step never overshoots
  always_comb begin
    if (seed2_q) begin
      avg_new = cur2_q;
    end else if (up2_q) begin
      avg_new = meta2_q.avg + step2_q;
    end else begin
      avg_new = meta2_q.avg - step2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= '{frame: meta2_q.frame, idx: meta2_q.idx, tag: meta2_q.tag,
               avg: avg_new, max: meta2_q.max};
  end

  assign out_vld_o = vld3_q;
  assign out_o     = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/zts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zts_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_vld_i,
  output logic                                  in_rdy_o,
  input  wire logic [zts_pkg::MODE_W-1:0]       in_mode_i,
  input  wire logic [zts_pkg::TAG_BITS-1:0]     in_tag_i,
  input  wire logic [zts_pkg::TIME_BITS-1:0]    in_dur_i,
  input  wire logic [zts_pkg::EIDX_W-1:0]       in_idx_i,
  output logic                                  ram_we_o,
  output logic [zts_pkg::IDX_BITS-1:0]          ram_waddr_o,
  output zts_pkg::entry_t                       ram_wdata_o,
  output logic [zts_pkg::IDX_BITS-1:0]          ram_raddr_o,
  input  wire zts_pkg::entry_t                  ram_rdata_i,
  output logic                                  sm_vld_o,
  output zts_pkg::smooth_in_t                   sm_in_o,
  input  wire logic                             sm_vld_i,
  input  wire zts_pkg::smooth_out_t             sm_out_i,
  output logic                                  res_vld_o,
  input  wire logic                             res_rdy_i,
  output zts_pkg::result_t                      res_o
);

  import zts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMT,
    S_CDRN,
    S_RD,
    S_FIN
  } state_e;

  state_e               state_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [TIME_BITS-1:0] dur_q;
  logic [CNT_BITS-1:0]  scan_q;
  logic                 rvld_q;
  logic [IDX_BITS-1:0]  ridx_q;
  logic [CNT_BITS-1:0]  used_q;
  logic [TIME_BITS-1:0] ftot_q, favg_q, fmax_q;
  logic [FRAMES_W-1:0]  ccnt_q;
  status_e              st_q;
  logic [TAG_BITS-1:0]  otag_q;
  logic [TIME_BITS-1:0] oavg_q, omax_q;

  logic issue, hit, miss, full;

  assign full  = used_q >= CNT_BITS'(ZONE_ENTRIES);
  assign issue = (state_q == S_SCAN || state_q == S_CMT) && (scan_q < used_q);
  assign hit   = (state_q == S_SCAN) && rvld_q && (ram_rdata_i.tag == tag_q);
  assign miss  = (state_q == S_SCAN) && !issue && !hit;

  assign in_rdy_o = (state_q == S_IDLE);

  // idle reads the slot asked for, so a read item finds its entry in the next cycle
  assign ram_raddr_o = (state_q == S_IDLE) ? IDX_BITS'(in_idx_i) : scan_q[IDX_BITS-1:0];

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = ridx_q;
    ram_wdata_o = ram_rdata_i;
    if (hit) begin
      ram_we_o        = 1'b1;
      ram_wdata_o.acc = sat_add(ram_rdata_i.acc, dur_q);
    end else if (miss && !full) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = used_q[IDX_BITS-1:0];
      ram_wdata_o = '{tag: tag_q, acc: dur_q, avg: '0, max: '0};
    end else if (sm_vld_i && !sm_out_i.frame) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = sm_out_i.idx;
      ram_wdata_o = '{tag: sm_out_i.tag, acc: '0, avg: sm_out_i.avg, max: sm_out_i.max};
    end
  end

  // entries stream in while reads go on; the frame total follows the last one
  always_comb begin
    sm_vld_o = (state_q == S_CMT) && (rvld_q || !issue);
    if (rvld_q) begin
      sm_in_o = '{frame: 1'b0, idx: ridx_q, tag: ram_rdata_i.tag,
                  cur: ram_rdata_i.acc, avg: ram_rdata_i.avg, max: ram_rdata_i.max};
    end else begin
      sm_in_o = '{frame: 1'b1, idx: '0, tag: '0, cur: ftot_q, avg: favg_q, max: fmax_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      rvld_q  <= 1'b0;
      used_q  <= '0;
      ftot_q  <= '0;
      favg_q  <= '0;
      fmax_q  <= '0;
      ccnt_q  <= '0;
      st_q    <= ST_INVALID;
    end else begin
      rvld_q <= issue;
      ridx_q <= scan_q[IDX_BITS-1:0];
      if (issue) begin
        scan_q <= scan_q + CNT_BITS'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_vld_i) begin
            tag_q  <= in_tag_i;
            dur_q  <= in_dur_i;
            scan_q <= '0;
            otag_q <= '0;
            oavg_q <= '0;
            omax_q <= '0;
            st_q   <= ST_INVALID;
            case (in_mode_i)
              MODE_SPAN:   state_q <= S_SCAN;
              MODE_COMMIT: state_q <= S_CMT;
              MODE_READ: begin
                state_q <= (32'(in_idx_i) < 32'(used_q)) ? S_RD : S_FIN;
              end
              default:     state_q <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          if (hit || miss) begin
            ftot_q  <= sat_add(ftot_q, dur_q);
            state_q <= S_FIN;
            if (hit) begin
              st_q <= ST_FOUND;
            end else if (!full) begin
              st_q   <= ST_NEW;
              used_q <= used_q + CNT_BITS'(1);
            end else begin
              st_q <= ST_DROPPED;
            end
          end
        end
        S_CMT: begin
          if (!issue && !rvld_q) begin
            state_q <= S_CDRN;
          end
        end
        S_CDRN: begin
          if (sm_vld_i && sm_out_i.frame) begin
            favg_q  <= sm_out_i.avg;
            fmax_q  <= sm_out_i.max;
            ftot_q  <= '0;
            ccnt_q  <= ccnt_q + FRAMES_W'(1);
            st_q    <= ST_COMMIT;
            oavg_q  <= sm_out_i.avg;
            omax_q  <= sm_out_i.max;
            state_q <= S_FIN;
          end
        end
        S_RD: begin
          st_q    <= ST_FOUND;
          otag_q  <= ram_rdata_i.tag;
          oavg_q  <= ram_rdata_i.avg;
          omax_q  <= ram_rdata_i.max;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (res_rdy_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_vld_o = (state_q == S_FIN);
  assign res_o = '{status: st_q, tag: ZTAG_W'(otag_q), avg: OTIME_W'(oavg_q),
                   max: OTIME_W'(omax_q), frames: ccnt_q, used: USED_W'(used_q)};

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_BITS'(ZONE_ENTRIES))
    else $error("entry count beyond table size");

  a_smooth_in_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sm_vld_i |-> (state_q == S_CMT || state_q == S_CDRN))
    else $error("smoothing result outside a commit");

  a_hit_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit || miss) |=> (state_q == S_FIN))
    else $error("lookup did not finish");

  a_drain_no_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CDRN) |-> (!rvld_q && !issue))
    else $error("entry read pending while draining commit");

endmodule

`default_nettype wire

// ===== rtl/core/zone_timing_statistics.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel      dir  handshake                     contents
// s_axis       in   s_axis_tvalid_i/tready_o      span, commit or read request
// m_axis       out  m_axis_tvalid_o/tready_i      one result beat per request
// cfg          in   cfg_we_i (no wait)            smoothing gain, seed threshold
//
// span: one entry per cycle is looked up through the table memory read port until
//   the tag is found or every used entry has been missed, then the result is handed
//   over and the sequencer goes back to idle
// commit: entries stream through the 3-stage smoothing pipeline, one per cycle, then
//   the frame total; the commit ends when the frame total leaves the pipeline
// read: a new request is taken while a result beat is still waiting
// reset clears counters and frame statistics at once; no memory clearing pass

module zone_timing_statistics (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // zone_tag, begin_time, end_time, entry_index, 2 zero pad bits
  input  wire logic [151:0] s_axis_tdata_i,
  // mode
  input  wire logic [1:0]   s_axis_tuser_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // out_tag, out_average, out_maximum, frames_committed, entries_used, 1 pad bit
  output logic [135:0]      m_axis_tdata_o,
  // status
  output logic [2:0]        m_axis_tuser_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [19:0]  cfg_data_i
);

  import zts_pkg::*;

  // input fields
  logic [ZTAG_W-1:0]   zone_tag;
  logic [STAMP_W-1:0]  begin_time, end_time, span_diff;
  logic [EIDX_W-1:0]   entry_index;
  logic [TIME_BITS-1:0] span_dur;

  assign zone_tag    = s_axis_tdata_i[15:0];
  assign begin_time  = s_axis_tdata_i[79:16];
  assign end_time    = s_axis_tdata_i[143:80];
  assign entry_index = s_axis_tdata_i[149:144];

  // span length, zero when end is not later, saturated to the time range
  assign span_diff = end_time - begin_time;
  always_comb begin
    if (end_time <= begin_time) begin
      span_dur = '0;
    end else if (|span_diff[STAMP_W-1:TIME_BITS]) begin
      span_dur = '1;
    end else begin
      span_dur = span_diff[TIME_BITS-1:0];
    end
  end

  // configuration registers
  logic [GAIN_W-1:0] gain_q;
  logic [THR_W-1:0]  thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_W'(5243);
      thresh_q <= THR_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_THRESH: thresh_q <= cfg_data_i[THR_W-1:0];
        default:    gain_q   <= gain_q;
      endcase
    end
  end

  // zone table memory
  logic                ram_we;
  logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;

  zts_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ZONE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // smoothing pipeline shared by all entries and the frame total
  logic        sm_in_vld, sm_out_vld;
  smooth_in_t  sm_in;
  smooth_out_t sm_out;

  zts_smooth u_smooth (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (sm_in_vld),
    .in_i      (sm_in),
    .gain_i    (gain_q),
    .thresh_i  (thresh_q),
    .out_vld_o (sm_out_vld),
    .out_o     (sm_out)
  );

  // sequencer
  logic    res_vld, res_rdy;
  result_t res;

  zts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (s_axis_tvalid_i),
    .in_rdy_o    (s_axis_tready_o),
    .in_mode_i   (s_axis_tuser_i),
    .in_tag_i    (TAG_BITS'(zone_tag)),
    .in_dur_i    (span_dur),
    .in_idx_i    (entry_index),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .sm_vld_o    (sm_in_vld),
    .sm_in_o     (sm_in),
    .sm_vld_i    (sm_out_vld),
    .sm_out_i    (sm_out),
    .res_vld_o   (res_vld),
    .res_rdy_i   (res_rdy),
    .res_o       (res)
  );

  // output register parts the sequencer from the result stream
  logic    out_vld_q;
  result_t out_q;

  assign res_rdy = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld && res_rdy) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld && res_rdy) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {1'b0, out_q.used, out_q.frames, out_q.max, out_q.avg, out_q.tag};

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import zts_pkg::*;

  // kind code with no meaning to the block, answered as an invalid read
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [39:0] TIME_CEIL = {40{1'b1}};

  // one result beat as the block should deliver it
  typedef struct packed {
    status_e     status;
    logic [15:0] tag;
    logic [39:0] avg;
    logic [39:0] peak;
    logic [31:0] frames;
    logic [6:0]  used;
  } zone_beat_t;

  // shadow of the zone table: predicts every result beat from the accepted
  // request beats and compares what comes out against it
  class zone_stats_board;
    logic [15:0] gain;
    logic [19:0] thresh;
    logic [15:0] slot_tag [64];
    logic [39:0] slot_sum [64];
    logic [39:0] slot_avg [64];
    logic [39:0] slot_peak [64];
    int unsigned used_entries;
    logic [39:0] frame_sum;
    logic [39:0] frame_avg;
    logic [39:0] frame_peak;
    logic [31:0] commits;
    zone_beat_t  zone_results_due [$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned spans_dropped;

    function new();
      gain = 16'd5243;
      thresh = 20'd100;
      foreach (slot_tag[i]) begin
        slot_tag[i] = '0;
        slot_sum[i] = '0;
        slot_avg[i] = '0;
        slot_peak[i] = '0;
      end
      used_entries = 0;
      frame_sum = '0;
      frame_avg = '0;
      frame_peak = '0;
      commits = '0;
      mismatches = 0;
      beats_checked = 0;
      spans_dropped = 0;
    endfunction

    function logic [39:0] saturating_sum(logic [39:0] a, logic [39:0] b);
      logic [40:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[40] ? TIME_CEIL : s[39:0];
    endfunction

    // low averages are reseeded, others move a rounded fraction toward cur
    function logic [39:0] smooth_toward(logic [39:0] old_avg, logic [39:0] cur);
      logic [63:0] mag;
      logic [63:0] step;
      if ({24'd0, old_avg} <= {44'd0, thresh}) return cur;
      mag = (cur >= old_avg) ? {24'd0, cur - old_avg} : {24'd0, old_avg - cur};
      step = (mag * {48'd0, gain} + 64'd32768) >> 16;
      return (cur >= old_avg) ? old_avg + step[39:0] : old_avg - step[39:0];
    endfunction

    function void apply_request(logic [1:0] mode, logic [15:0] tag, logic [63:0] t0,
                                logic [63:0] t1, logic [5:0] idx);
      zone_beat_t r;
      logic [63:0] dur;
      logic [39:0] span;
      bit hit;
      r = '0;
      r.status = ST_INVALID;
      hit = 0;
      case (mode)
        MODE_SPAN: begin
          dur = (t1 > t0) ? t1 - t0 : 64'd0;
          span = (dur > {24'd0, TIME_CEIL}) ? TIME_CEIL : dur[39:0];
          for (int i = 0; i < used_entries && !hit; i++) begin
            if (slot_tag[i] == tag) begin
              slot_sum[i] = saturating_sum(slot_sum[i], span);
              hit = 1;
            end
          end
          if (hit) begin
            r.status = ST_FOUND;
          end else if (used_entries < 64) begin
            slot_tag[used_entries] = tag;
            slot_sum[used_entries] = span;
            slot_avg[used_entries] = '0;
            slot_peak[used_entries] = '0;
            used_entries++;
            r.status = ST_NEW;
          end else begin
            r.status = ST_DROPPED;
            spans_dropped++;
          end
          frame_sum = saturating_sum(frame_sum, span);
        end
        MODE_COMMIT: begin
          for (int i = 0; i < used_entries; i++) begin
            slot_avg[i] = smooth_toward(slot_avg[i], slot_sum[i]);
            if (slot_sum[i] > slot_peak[i]) slot_peak[i] = slot_sum[i];
            slot_sum[i] = '0;
          end
          frame_avg = smooth_toward(frame_avg, frame_sum);
          if (frame_sum > frame_peak) frame_peak = frame_sum;
          frame_sum = '0;
          commits++;
          r.status = ST_COMMIT;
          r.avg = frame_avg;
          r.peak = frame_peak;
        end
        MODE_READ: begin
          if (idx < used_entries) begin
            r.status = ST_FOUND;
            r.tag = slot_tag[idx];
            r.avg = slot_avg[idx];
            r.peak = slot_peak[idx];
          end
        end
        default: ;
      endcase
      r.frames = commits;
      r.used = 7'(used_entries);
      zone_results_due.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch in %s at %0t: got %0h, want %0h", field, $time, got, want);
    endtask

    task check_result_beat(logic [2:0] status, logic [135:0] data);
      zone_beat_t w;
      if (zone_results_due.size() == 0) begin
        report("unexpected result beat", {61'd0, status}, 64'd0);
        return;
      end
      w = zone_results_due.pop_front();
      beats_checked++;
      if (status !== w.status)        report("status", {61'd0, status}, {61'd0, w.status});
      if (data[15:0] !== w.tag)       report("out_tag", {48'd0, data[15:0]}, {48'd0, w.tag});
      if (data[55:16] !== w.avg)      report("out_average", {24'd0, data[55:16]}, {24'd0, w.avg});
      if (data[95:56] !== w.peak)     report("out_maximum", {24'd0, data[95:56]}, {24'd0, w.peak});
      if (data[127:96] !== w.frames)
        report("frames_committed", {32'd0, data[127:96]}, {32'd0, w.frames});
      if (data[134:128] !== w.used)   report("entries_used", {57'd0, data[134:128]}, {57'd0, w.used});
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic [151:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         s_tvalid;
  wire          s_tready;
  wire  [135:0] m_tdata;
  wire  [2:0]   m_tuser;
  wire          m_tvalid;
  logic         m_tready;
  logic         cfg_we;
  logic         cfg_idx;
  logic [19:0]  cfg_data;

  zone_stats_board sb;

  // 0 no idling, 1 sender idles, 2 receiver stalls, 3 both now and then
  int unsigned idle_mode;
  // cycles of receiver hold-off asked by the main sequence
  int unsigned hold_request;

  int unsigned n_span, n_commit, n_read, n_other;
  logic [15:0] tag_pool [$];

  zone_timing_statistics DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit sender_pauses();
    if (idle_mode == 1) return $urandom_range(99) < 66;
    if (idle_mode == 3) return $urandom_range(99) < 12;
    return 0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == 2) return $urandom_range(99) < 66;
    if (idle_mode == 3) return $urandom_range(99) < 12;
    return 0;
  endfunction

  // offer one request beat and hold it until the block takes it; valid
  // stays high into the next call when no idle gap follows
  task automatic offer_request(logic [1:0] mode, logic [15:0] tag, logic [63:0] t0,
                               logic [63:0] t1, logic [5:0] idx);
    while (sender_pauses()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, idx, t1, t0, tag};
    do @(posedge clk); while (!s_tready);
    sb.apply_request(mode, tag, t0, t1, idx);
    case (mode)
      MODE_SPAN:   n_span++;
      MODE_COMMIT: n_commit++;
      MODE_READ:   n_read++;
      default:     n_other++;
    endcase
  endtask

  // both registers back to back, write enable held high across the pair
  task automatic program_statistics(logic [15:0] gain, logic [19:0] thresh);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_GAIN;
    cfg_data <= {4'd0, gain};
    @(posedge clk);
    cfg_idx  <= CFG_THRESH;
    cfg_data <= thresh;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.gain = gain;
    sb.thresh = thresh;
  endtask

  // every predicted beat delivered, then a margin for the longest walk
  task automatic settle();
    while (sb.zone_results_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic run_directed();
    // a read and a commit on an empty table
    offer_request(MODE_READ, 16'h0000, 64'd0, 64'd0, 6'd0);
    offer_request(MODE_COMMIT, 16'h0000, 64'd0, 64'd0, 6'd0);
    // zero length, full-range span that saturates, then accumulator overflow
    offer_request(MODE_SPAN, 16'h0000, 64'd0, 64'd0, 6'd0);
    offer_request(MODE_SPAN, 16'hFFFF, 64'd0, '1, 6'h3F);
    offer_request(MODE_SPAN, 16'hFFFF, 64'd100, 64'd200, 6'd0);
    // end before begin, and end equal to begin
    offer_request(MODE_SPAN, 16'h0000, '1, 64'd0, 6'd0);
    offer_request(MODE_SPAN, 16'h1234, 64'd1000, 64'd1050, 6'd0);
    offer_request(MODE_SPAN, 16'h1234, 64'd5, 64'd5, 6'd0);
    // frame total is saturated here, every entry gets seeded
    offer_request(MODE_COMMIT, 16'h0000, 64'd0, 64'd0, 6'd0);
    offer_request(MODE_READ, 16'h0000, 64'd0, 64'd0, 6'd0);
    offer_request(MODE_READ, 16'h0000, 64'd0, 64'd0, 6'd1);
    offer_request(MODE_READ, 16'h0000, 64'd0, 64'd0, 6'd2);
    offer_request(MODE_READ, 16'h0000, 64'd0, 64'd0, 6'd3);
    offer_request(MODE_READ, 16'hFFFF, '1, '1, 6'h3F);
    // low average reseeded, then smoothed down and up
    offer_request(MODE_SPAN, 16'h1234, 64'd0, 64'd5000, 6'd0);
    offer_request(MODE_COMMIT, 16'h0000, 64'd0, 64'd0, 6'd0);
    offer_request(MODE_SPAN, 16'h1234, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0BB8, 6'd0);
    offer_request(MODE_COMMIT, 16'h0000, 64'd0, 64'd0, 6'd0);
    offer_request(MODE_SPAN, 16'h1234, 64'd0, 64'd20000, 6'd0);
    offer_request(MODE_COMMIT, 16'h0000, 64'd0, 64'd0, 6'd0);
    offer_request(MODE_READ, 16'h0000, 64'd0, 64'd0, 6'd2);
    // kind code three with every field bit set
    offer_request(MODE_UNUSED, 16'hFFFF, '1, '1, 6'h3F);
    offer_request(MODE_READ, 16'h0000, 64'd0, 64'd0, 6'd1);
    s_tvalid <= 1'b0;
  endtask

  // mostly spans on a growing pool of tags, with commits, reads and noise;
  // fresh tags keep coming so the table fills and later spans get dropped
  task automatic run_mixed_phase(int unsigned count);
    int unsigned pick;
    int unsigned kind;
    logic [15:0] tag;
    logic [63:0] t0;
    logic [63:0] t1;
    logic [5:0]  idx;
    repeat (count) begin
      pick = $urandom_range(99);
      tag = 16'($urandom);
      t0 = {$urandom, $urandom};
      t1 = {$urandom, $urandom};
      idx = 6'($urandom);
      if (pick < 60) begin
        if (tag_pool.size() == 0 || $urandom_range(9) == 0) tag_pool.push_back(tag);
        else tag = tag_pool[$urandom_range(tag_pool.size() - 1)];
        kind = $urandom_range(9);
        if (kind < 6) t1 = t0 + 64'($urandom_range(5000));
        else if (kind == 6) t1 = t0 + 64'($urandom);
        else if (kind == 7) t1 = t0 - 64'($urandom_range(1000));
        else if (kind == 9) t1 = t0 + (64'd1 << $urandom_range(63, 40));
        offer_request(MODE_SPAN, tag, t0, t1, idx);
      end else if (pick < 75) begin
        offer_request(MODE_COMMIT, tag, t0, t1, idx);
      end else if (pick < 95) begin
        // mostly live entries, sometimes anywhere in the index range
        if (sb.used_entries != 0 && $urandom_range(3) != 0)
          idx = 6'($urandom_range(sb.used_entries - 1));
        offer_request(MODE_READ, tag, t0, t1, idx);
      end else begin
        offer_request(MODE_UNUSED, tag, t0, t1, idx);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  // result side: check each accepted beat, then pick next cycle's ready;
  // a requested hold-off is counted down here, one cycle per edge
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result_beat(m_tuser, m_tdata);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !receiver_stalls();
      end
    end
  end

  initial begin
    int unsigned p;
    logic [15:0] gain;
    logic [19:0] thresh;
    sb = new();
    idle_mode = 0;
    hold_request = 0;
    n_span = 0;
    n_commit = 0;
    n_read = 0;
    n_other = 0;
    rst_n    <= 1'b0;
    s_tvalid <= 1'b0;
    s_tuser  <= '0;
    s_tdata  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_GAIN;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats run on the reset register values
    run_directed();
    settle();

    // six random phases, each with its own register setting; the idling style cycles through the four modes
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin gain = 16'd5243;  thresh = 20'd100;     end
        1: begin gain = 16'd0;     thresh = 20'd0;       end
        2: begin gain = 16'hFFFF;  thresh = 20'hFFFFF;   end
        3: begin gain = 16'hFFFF;  thresh = 20'd0;       end
        4: begin gain = 16'($urandom); thresh = 20'($urandom_range(5000)); end
        default: begin gain = 16'($urandom); thresh = 20'($urandom); end
      endcase
      program_statistics(gain, thresh);
      idle_mode = p % 4;
      // long receiver hold-off while requests keep coming, so the block backs up
      if (p == 4) hold_request = 300;
      run_mixed_phase(300);
      settle();
    end

    $display("covered %0d requests: %0d spans, %0d commits, %0d reads, %0d unused kind",
             n_span + n_commit + n_read + n_other, n_span, n_commit, n_read, n_other);
    $display("%0d result beats checked, table filled to %0d, %0d spans dropped, 7 settings",
             sb.beats_checked, sb.used_entries, sb.spans_dropped);
    if (sb.mismatches == 0 && sb.zone_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/zts_pkg.sv
rtl/core/zts_ram.sv
rtl/core/zts_smooth.sv
rtl/core/zts_ctrl.sv
rtl/core/zone_timing_statistics.sv
dv/tb.sv
